// ----- rtl/upd_pkg.sv -----
// ----------------------------------------------------------------------------
// upd_pkg: shared types and helpers for the URL percent decoder
// Holds character codes, the front-to-back command word and the small
// classification functions for hex digits and UTF-8 lead bytes.
// ----------------------------------------------------------------------------
`default_nettype none

package upd_pkg;

    localparam logic [7:0] CH_PCT = 8'h25;  // '%'
    localparam logic [7:0] CH_0   = 8'h30;  // '0'
    localparam logic [7:0] CH_9   = 8'h39;  // '9'
    localparam logic [7:0] CH_UA  = 8'h41;  // 'A'
    localparam logic [7:0] CH_UF  = 8'h46;  // 'F'
    localparam logic [7:0] CH_LA  = 8'h61;  // 'a'
    localparam logic [7:0] CH_LF  = 8'h66;  // 'f'
    localparam logic [7:0] HEX_TEN = 8'd10;

    // depth of the queue between decoder and UTF-8 checker
    localparam int Q_DEPTH = 2;

    // one decoded step handed from the front to the back
    typedef struct packed {
        logic       has_byte;
        logic [7:0] data;
        logic       last;
    } t_cmd;

    // {valid, value}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        begin
            v = 8'd0;
            if (c inside {[CH_0:CH_9]}) begin
                v = c - CH_0;
                return {1'b1, v[3:0]};
            end
            if (c inside {[CH_UA:CH_UF]}) begin
                v = c - CH_UA + HEX_TEN;
                return {1'b1, v[3:0]};
            end
            if (c inside {[CH_LA:CH_LF]}) begin
                v = c - CH_LA + HEX_TEN;
                return {1'b1, v[3:0]};
            end
            return 5'd0;
        end
    endfunction

    // sequence length for a lead byte, zero when it cannot start one
    function automatic logic [2:0] lead_length(input logic [7:0] c, input logic four_ok);
        begin
            if (c inside {[8'hC0:8'hDF]}) return 3'd2;
            if (c inside {[8'hE0:8'hEF]}) return 3'd3;
            if ((c inside {[8'hF0:8'hF7]}) && four_ok) return 3'd4;
            return 3'd0;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/upd_front.sv -----
// ----------------------------------------------------------------------------
// upd_front: percent-escape decoder
// Turns raw bytes into decoded bytes, tracks the stop condition and emits
// one command per accepted byte that yields data or ends the string.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_front
    import upd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_end_of_input,
    output logic            o_push,
    output t_cmd            o_cmd
);

    typedef enum logic [2:0] {
        PH_NORMAL = 3'b001,
        PH_HIGH   = 3'b010,
        PH_LOW    = 3'b100
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [3:0] r_high, n_high;
    logic       r_stopped, n_stopped;

    logic [4:0] hx;
    logic       have_v;
    logic [7:0] have;

    always_comb begin
        n_phase   = r_phase;
        n_high    = r_high;
        n_stopped = r_stopped;
        have_v    = 1'b0;
        have      = i_in_byte;
        hx        = hex_value(i_in_byte);
        if (!r_stopped) begin
            case (r_phase)
                PH_NORMAL: begin
                    if (i_in_byte == CH_PCT) begin
                        n_phase = PH_HIGH;
                    end else begin
                        have_v = 1'b1;
                    end
                end
                PH_HIGH: begin
                    if (!hx[4]) begin
                        n_stopped = 1'b1;
                    end else begin
                        n_high  = hx[3:0];
                        n_phase = PH_LOW;
                    end
                end
                PH_LOW: begin
                    if (!hx[4]) begin
                        n_stopped = 1'b1;
                    end else begin
                        have    = {r_high, hx[3:0]};
                        have_v  = 1'b1;
                        n_phase = PH_NORMAL;
                    end
                end
                default: begin
                    n_phase = PH_NORMAL;
                end
            endcase
            // a zero byte ends the output
            if (have_v && (have == 8'd0)) begin
                have_v    = 1'b0;
                n_stopped = 1'b1;
            end
        end
        if (i_end_of_input) begin
            n_phase   = PH_NORMAL;
            n_high    = 4'd0;
            n_stopped = 1'b0;
        end
    end

    assign o_push        = i_accept && (have_v || i_end_of_input);
    assign o_cmd         = '{has_byte: have_v, data: have, last: i_end_of_input};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_NORMAL;
            r_high    <= 4'd0;
            r_stopped <= 1'b0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_high    <= n_high;
            r_stopped <= n_stopped;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/upd_queue.sv -----
// ----------------------------------------------------------------------------
// upd_queue: short command queue
// Decouples the escape decoder from the UTF-8 checker.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_queue
    import upd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_cmd      o_head
);

    localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(Q_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(Q_DEPTH);

    t_cmd          r_slot [Q_DEPTH];
    logic [AW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_cnt;

    logic do_push, do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_slot[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == LAST_IDX) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LAST_IDX) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/upd_back.sv -----
// ----------------------------------------------------------------------------
// upd_back: UTF-8 checker and Latin-1 repair
// Scans decoded bytes one step a cycle unless output waits, holds lead and
// continuation bytes, drains emitted bytes one a cycle into a free result reg.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_back
    import upd_pkg::*;
#(
    parameter int MAX_SEQ_BYTES = 4
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_q_empty,
    input  wire t_cmd  i_q_head,
    output logic       o_q_pop,
    input  wire logic  i_pop,
    output logic       o_empty,
    output logic [7:0] o_out_byte,
    output logic       o_byte_present,
    output logic       o_run_last,
    output logic       o_string_end
);

    localparam logic FOUR_OK = (MAX_SEQ_BYTES >= 4);

    // held sequence
    logic [7:0] r_pend [3];
    logic [7:0] n_pend [3];
    logic [1:0] r_pcnt, n_pcnt;
    // bytes still to scan
    logic [7:0] r_sb [3];
    logic [7:0] n_sb [3];
    logic [1:0] r_scnt, n_scnt;
    // bytes waiting to leave
    logic [7:0] r_ebuf [4];
    logic [7:0] n_ebuf [4];
    logic [2:0] r_ecnt, n_ecnt;
    // newest emitted byte, held until we know whether it ends the run
    logic [7:0] r_hold, n_hold;
    logic       r_hold_v, n_hold_v;
    logic       r_busy, n_busy;
    logic       r_flush, n_flush;
    // result register
    logic       r_out_v;
    logic [7:0] r_out_byte;
    logic       r_out_present, r_out_run_last, r_out_end;

    logic        out_can;
    logic        push_out;
    logic [7:0]  push_byte;
    logic        push_present, push_run_last, push_end;

    logic [7:0]  c;
    logic [2:0]  need;
    logic        is_cont;
    logic        seq_ok;
    logic        broken;
    logic        done;
    logic [1:0]  np;
    logic [2:0]  nsum;
    logic [10:0] v2;
    logic [15:0] v3;
    logic [20:0] v4;

    assign out_can = !r_out_v || i_pop;
    assign c       = r_sb[0];
    assign need    = lead_length(r_pend[0], FOUR_OK);
    assign is_cont = (c[7:6] == 2'b10);
    assign v2      = {r_pend[0][4:0], c[5:0]};
    assign v3      = {r_pend[0][3:0], r_pend[1][5:0], c[5:0]};
    assign v4      = {r_pend[0][2:0], r_pend[1][5:0], r_pend[2][5:0], c[5:0]};
    assign done    = r_busy && (r_ecnt == 3'd0) && (r_scnt == 2'd0)
                     && (!r_flush || (r_pcnt == 2'd0));

    always_comb begin
        case (need)
            3'd2:    seq_ok = (v2 >= 11'h080);
            3'd3:    seq_ok = (v3 >= 16'h0800);
            3'd4:    seq_ok = (v4 >= 21'h010000) && (v4 <= 21'h10FFFF);
            default: seq_ok = 1'b0;
        endcase
    end

    always_comb begin
        n_pend   = r_pend;
        n_pcnt   = r_pcnt;
        n_sb     = r_sb;
        n_scnt   = r_scnt;
        n_ebuf   = r_ebuf;
        n_ecnt   = r_ecnt;
        n_hold   = r_hold;
        n_hold_v = r_hold_v;
        n_busy   = r_busy;
        n_flush  = r_flush;
        o_q_pop  = 1'b0;
        push_out      = 1'b0;
        push_byte     = r_hold;
        push_present  = 1'b1;
        push_run_last = 1'b0;
        push_end      = 1'b0;
        broken   = 1'b0;
        np       = 2'd0;
        nsum     = 3'd0;

        if (r_ecnt != 3'd0) begin
            // drain one byte through the hold register
            if (!r_hold_v || out_can) begin
                push_out  = r_hold_v;
                n_hold    = r_ebuf[0];
                n_hold_v  = 1'b1;
                n_ebuf[0] = r_ebuf[1];
                n_ebuf[1] = r_ebuf[2];
                n_ebuf[2] = r_ebuf[3];
                n_ecnt    = r_ecnt - 3'd1;
            end
        end else if (done) begin
            // close the run: tag the last byte or send a bare end marker
            if (r_hold_v || r_flush) begin
                if (out_can) begin
                    push_out      = 1'b1;
                    push_byte     = r_hold_v ? r_hold : 8'd0;
                    push_present  = r_hold_v;
                    push_run_last = 1'b1;
                    push_end      = r_flush;
                    n_hold_v      = 1'b0;
                    n_busy        = 1'b0;
                end
            end else begin
                n_busy = 1'b0;
            end
        end else if (r_busy) begin
            if (r_pcnt == 2'd0) begin
                // fresh byte with nothing held
                n_sb[0] = r_sb[1];
                n_sb[1] = r_sb[2];
                n_scnt  = r_scnt - 2'd1;
                if (!c[7]) begin
                    n_ebuf[0] = c;
                    n_ecnt    = 3'd1;
                end else if (lead_length(c, FOUR_OK) != 3'd0) begin
                    n_pend[0] = c;
                    n_pcnt    = 2'd1;
                end else begin
                    n_ebuf[0] = {6'b110000, c[7:6]};
                    n_ebuf[1] = {2'b10, c[5:0]};
                    n_ecnt    = 3'd2;
                end
            end else begin
                if (r_scnt == 2'd0) begin
                    broken = 1'b1;
                end else if (is_cont) begin
                    if (({1'b0, r_pcnt} + 3'd1) >= need) begin
                        if (seq_ok) begin
                            // complete sequence: send it as is
                            n_ebuf[0] = r_pend[0];
                            n_ebuf[1] = r_pend[1];
                            n_ebuf[2] = r_pend[2];
                            n_ebuf[r_pcnt] = c;
                            n_ecnt    = {1'b0, r_pcnt} + 3'd1;
                            n_pcnt    = 2'd0;
                            n_sb[0]   = r_sb[1];
                            n_sb[1]   = r_sb[2];
                            n_scnt    = r_scnt - 2'd1;
                        end else begin
                            broken = 1'b1;
                        end
                    end else begin
                        if (r_pcnt == 2'd1) begin
                            n_pend[1] = c;
                        end else begin
                            n_pend[2] = c;
                        end
                        n_pcnt  = r_pcnt + 2'd1;
                        n_sb[0] = r_sb[1];
                        n_sb[1] = r_sb[2];
                        n_scnt  = r_scnt - 2'd1;
                    end
                end else begin
                    broken = 1'b1;
                end
                if (broken) begin
                    // lead as Latin-1, rescan the held tail ahead of the rest
                    n_ebuf[0] = {6'b110000, r_pend[0][7:6]};
                    n_ebuf[1] = {2'b10, r_pend[0][5:0]};
                    n_ecnt    = 3'd2;
                    n_pcnt    = 2'd0;
                    np        = r_pcnt - 2'd1;
                    case (np)
                        2'd1: begin
                            n_sb[0] = r_pend[1];
                            n_sb[1] = r_sb[0];
                            n_sb[2] = r_sb[1];
                        end
                        2'd2: begin
                            n_sb[0] = r_pend[1];
                            n_sb[1] = r_pend[2];
                            n_sb[2] = r_sb[0];
                        end
                        default: begin
                            n_sb = r_sb;
                        end
                    endcase
                    nsum   = {1'b0, np} + {1'b0, r_scnt};
                    n_scnt = (nsum > 3'd3) ? 2'd3 : nsum[1:0];
                end
            end
        end else if (!i_q_empty) begin
            // load the next command
            o_q_pop = 1'b1;
            n_sb[0] = i_q_head.data;
            n_scnt  = i_q_head.has_byte ? 2'd1 : 2'd0;
            n_flush = i_q_head.last;
            n_busy  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_sb   <= n_sb;
        r_ebuf <= n_ebuf;
        r_hold <= n_hold;
        if (push_out) begin
            r_out_byte     <= push_byte;
            r_out_present  <= push_present;
            r_out_run_last <= push_run_last;
            r_out_end      <= push_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcnt   <= 2'd0;
            r_scnt   <= 2'd0;
            r_ecnt   <= 3'd0;
            r_hold_v <= 1'b0;
            r_busy   <= 1'b0;
            r_flush  <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_pcnt   <= n_pcnt;
            r_scnt   <= n_scnt;
            r_ecnt   <= n_ecnt;
            r_hold_v <= n_hold_v;
            r_busy   <= n_busy;
            r_flush  <= n_flush;
            if (push_out) begin
                r_out_v <= 1'b1;
            end else if (i_pop) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_empty        = !r_out_v;
    assign o_out_byte     = r_out_byte;
    assign o_byte_present = r_out_present;
    assign o_run_last     = r_out_run_last;
    assign o_string_end   = r_out_end;

endmodule

`default_nettype wire

// ----- rtl/url_percent_decode_utf8_repair_top.sv -----
// ----------------------------------------------------------------------------
// url_percent_decode_utf8_repair_top: URL unescaper with UTF-8 repair
// Decodes %XY escapes and repairs invalid UTF-8 by re-encoding it as Latin-1.
// Usage:
//   Input queue: drive i_in_byte / i_end_of_input and raise push; a word is
//   taken on a clock edge with push high and full low. The escape decoder
//   works in the same cycle and drops its result into a two-entry queue.
//   Result queue: while empty is low, o_out_byte and its flags show the
//   oldest result word; raise pop to take it.
//   Each input word yields zero or more result words; o_run_last marks the
//   last one of a word, o_string_end the last one of the string, and a word
//   with i_end_of_input always yields at least a bare end marker.
// Timing:
//   The checker loop runs one step a cycle while the output is not held
//   back, and sets the rate: it loads a word, takes its scan steps, emits
//   each byte and closes the run before it loads the next word. The queue
//   lets the decoder take new input words in the meantime.
// Reset: synchronous, active low; clears decoder state, checker counts and
//   flags, and both queues. If the receiver holds off pop, the result
//   register stays full, the checker stops, the queue fills, and full rises.
// ----------------------------------------------------------------------------
`default_nettype none

module url_percent_decode_utf8_repair_top
    import upd_pkg::*;
#(
    parameter int MAX_SEQ_BYTES = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_end_of_input,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_out_byte,
    output logic            o_byte_present,
    output logic            o_run_last,
    output logic            o_string_end
);

    logic accept;
    logic q_push, q_pop, q_full, q_empty;
    t_cmd cmd, q_head;

    // take a word only when the queue has room
    assign accept = push && !q_full;
    assign full   = q_full;

    upd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .o_push         (q_push),
        .o_cmd          (cmd)
    );

    upd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    upd_back #(
        .MAX_SEQ_BYTES (MAX_SEQ_BYTES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_head       (q_head),
        .o_q_pop        (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_out_byte     (o_out_byte),
        .o_byte_present (o_byte_present),
        .o_run_last     (o_run_last),
        .o_string_end   (o_string_end)
    );

endmodule

`default_nettype wire
